>>> sv/huffman_code_bit_packer_assert.svh
// assertion macros shared by the huffman code bit packer rtl
// expects clk and rst_n in the scope of each use
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define HCBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define HCBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/hcbp_pkg.sv
// package for the huffman code bit packer: constants and item kinds
// no dependencies
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int MAX_CODE_BITS_DEF = 32;
  localparam int ALPHABET_SIZE_DEF = 256;
  localparam int BYTE_BITS         = 8;
  localparam int QUEUE_DEPTH       = 4;

  localparam int MODE_W      = 2;
  localparam int SYMBOL_W    = 8;
  localparam int CODE_IN_W   = 32;
  localparam int LEN_IN_W    = 6;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

endpackage

>>> sv/hcbp_front.sv
// front end: accepts items, owns the code table, queues encode and flush commands
// depends on hcbp_pkg
`timescale 1ns / 1ps

`include "huffman_code_bit_packer_assert.svh"

module hcbp_front import hcbp_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  localparam int LW = $clog2(MAX_CODE_BITS + 1),
  localparam int QW = 1 + LW + MAX_CODE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  mode_t                 in_mode,
  input  logic [SYMBOL_W-1:0]   in_symbol,
  input  logic [CODE_IN_W-1:0]  in_code_bits,
  input  logic [LEN_IN_W-1:0]   in_code_length,
  output logic                  q_push,
  output logic [QW-1:0]         q_wdata,
  input  logic                  q_full
);

  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int EW = LW + MAX_CODE_BITS;

  logic [EW-1:0]            table_mem [ALPHABET_SIZE];
  logic [EW-1:0]            rd_data_r;
  logic                     s1_valid_r, s1_valid_nxt;
  logic                     s1_flush_r, s1_flush_nxt;
  logic                     accept;
  logic                     sym_ok;
  logic                     tbl_wr;
  logic [AW-1:0]            addr;
  logic [LW-1:0]            len_sat;
  logic [MAX_CODE_BITS-1:0] code_mask;
  logic [MAX_CODE_BITS-1:0] code_keep;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !s1_valid_r || !q_full;
  assign q_push    = s1_valid_r && !q_full;
  assign sym_ok    = {1'b0, in_symbol} < (SYMBOL_W + 1)'(ALPHABET_SIZE);
  assign addr      = in_symbol[AW-1:0];
  assign tbl_wr    = accept && (in_mode == MODE_LOAD) && sym_ok;

  // saturate length and drop code bits above it
  assign len_sat   = (in_code_length > LEN_IN_W'(MAX_CODE_BITS)) ?
                     LW'(MAX_CODE_BITS) : in_code_length[LW-1:0];
  assign code_mask = ~({MAX_CODE_BITS{1'b1}} << len_sat);
  assign code_keep = in_code_bits[MAX_CODE_BITS-1:0] & code_mask;

  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      table_mem[addr] <= {len_sat, code_keep};
    end
    if (accept) begin
      rd_data_r <= table_mem[addr];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_flush_nxt = s1_flush_r;
    if (accept) begin
      s1_valid_nxt = ((in_mode == MODE_ENCODE) && sym_ok) || (in_mode == MODE_FLUSH);
      s1_flush_nxt = (in_mode == MODE_FLUSH);
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_flush_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_flush_r <= s1_flush_nxt;
    end
  end

  assign q_wdata = {s1_flush_r, rd_data_r};

  `HCBP_ASSERT_NXT(a_front_hold, s1_valid_r && q_full, s1_valid_r, "queued command lost")

endmodule

>>> sv/hcbp_queue.sv
// short command queue between front and back ends
// depends on hcbp_pkg
`timescale 1ns / 1ps

`include "huffman_code_bit_packer_assert.svh"

module hcbp_queue import hcbp_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         not_empty
);

  localparam int PW = $clog2(DEPTH);

  logic [W-1:0] slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;

  assign full      = (count_r == (PW + 1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `HCBP_ASSERT_IMP(a_q_no_overflow, push, !full, "push into full queue")
  `HCBP_ASSERT_IMP(a_q_no_underflow, pop, not_empty, "pop from empty queue")

endmodule

>>> sv/hcbp_back.sv
// back end: bit accumulator and byte emitter with output register
// depends on hcbp_pkg
`timescale 1ns / 1ps

`include "huffman_code_bit_packer_assert.svh"

module hcbp_back import hcbp_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  localparam int LW = $clog2(MAX_CODE_BITS + 1),
  localparam int QW = 1 + LW + MAX_CODE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  logic [QW-1:0]        q_rdata,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [BYTE_BITS-1:0] out_byte,
  output logic                 out_last
);

  localparam int ACC_W = MAX_CODE_BITS + BYTE_BITS - 1;
  localparam int TW    = $clog2(ACC_W + 1);

  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic [TW-1:0]            total_r, total_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [BYTE_BITS-1:0]     out_byte_r, out_byte_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     cmd_flush;
  logic [LW-1:0]            cmd_len;
  logic [MAX_CODE_BITS-1:0] cmd_code;
  logic                     out_free;
  logic                     emit;
  logic                     flush_emit;
  logic [TW-1:0]            cur_total;
  logic [TW-1:0]            rem_total;
  logic [2:0]               pend_cnt;
  logic [BYTE_BITS-2:0]     pend;
  logic [ACC_W-1:0]         shifted;
  logic [BYTE_BITS-1:0]     flush_byte;

  assign cmd_flush = q_rdata[QW-1];
  assign cmd_len   = q_rdata[QW-2 -: LW];
  assign cmd_code  = q_rdata[MAX_CODE_BITS-1:0];

  assign out_free  = !out_valid_r || out_tready;
  assign rem_total = total_r - TW'(BYTE_BITS);
  assign emit      = (total_r >= TW'(BYTE_BITS)) && out_free;
  assign cur_total = emit ? rem_total : total_r;
  assign pend_cnt  = cur_total[2:0];

  // bits still pending after this cycle's byte, right aligned
  assign pend      = acc_r[BYTE_BITS-2:0] & ~(7'h7f << pend_cnt);
  assign shifted   = acc_r >> rem_total;
  assign flush_byte = {1'b0, pend} << (4'd8 - {1'b0, pend_cnt});

  always_comb begin
    q_pop      = 1'b0;
    flush_emit = 1'b0;
    if (q_valid && (cur_total < TW'(BYTE_BITS))) begin
      if (!cmd_flush) begin
        q_pop = 1'b1;
      end else if (cur_total == '0) begin
        q_pop = 1'b1;
      end else if (out_free && !emit) begin
        q_pop      = 1'b1;
        flush_emit = 1'b1;
      end
    end
  end

  always_comb begin
    acc_nxt   = acc_r;
    total_nxt = cur_total;
    if (q_pop) begin
      if (cmd_flush) begin
        total_nxt = '0;
      end else begin
        acc_nxt   = (ACC_W'(pend) << cmd_len) | ACC_W'(cmd_code);
        total_nxt = cur_total + TW'(cmd_len);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    priority if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = shifted[BYTE_BITS-1:0];
      out_last_nxt  = (rem_total < TW'(BYTE_BITS));
    end else if (flush_emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = flush_byte;
      out_last_nxt  = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;

  `HCBP_ASSERT_NXT(a_flush_clears, q_pop && cmd_flush, total_r == '0, "flush left bits")
  `HCBP_ASSERT_IMP(a_pop_drained, q_pop, cur_total < TW'(BYTE_BITS), "pop with bytes left")

endmodule

>>> sv/huffman_code_bit_packer.sv
// top level of the huffman code bit packer
// depends on hcbp_pkg, hcbp_front, hcbp_queue, hcbp_back
`timescale 1ns / 1ps

// usage
// - input stream: in_tuser selects the item kind (load table entry, encode, flush);
//   in_tdata carries symbol, code bits and code length
// - output stream: one packed byte per transfer, earliest bit in bit 7;
//   out_tlast marks the last byte an input item produces
// - a load writes one table entry; a symbol must be loaded before it is encoded
// - an encode appends the code msb first and emits each byte it completes
// - a flush emits the partial byte padded with zeros and clears the accumulator
// - path of an encode byte with nothing queued ahead: table read register, queue,
//   accumulator, output register; a flush byte bypasses the accumulator register
// - throughput: the accumulator emits one byte per cycle while the output is free;
//   a code is taken once fewer than eight bits remain, a flush waits while a byte
//   is emitted; loads are consumed at the input and never enter the queue
// - a four-entry command queue sits between table lookup and accumulator, so
//   input keeps flowing while bytes wait
// - reset clears the accumulator count, queue and output valid; the code table holds
//   no reset value and must be loaded
// - when out_tready is low the output byte holds, the queue fills, then in_tready drops

module huffman_code_bit_packer import hcbp_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // symbol, code_bits, code_length, zero pad
  input  logic [MODE_W-1:0]      in_tuser,   // mode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_byte
  output logic                   out_tlast
);

  localparam int LW = $clog2(MAX_CODE_BITS + 1);
  localparam int QW = 1 + LW + MAX_CODE_BITS;

  logic          q_push;
  logic [QW-1:0] q_wdata;
  logic          q_full;
  logic          q_pop;
  logic [QW-1:0] q_rdata;
  logic          q_valid;
  mode_t         in_mode;

  assign in_mode = mode_t'(in_tuser);

  hcbp_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_mode        (in_mode),
    .in_symbol      (in_tdata[7:0]),
    .in_code_bits   (in_tdata[39:8]),
    .in_code_length (in_tdata[45:40]),
    .q_push         (q_push),
    .q_wdata        (q_wdata),
    .q_full         (q_full)
  );

  hcbp_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_valid)
  );

  hcbp_back #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule
